// ===== rtl/core/masked_byte_pattern_scanner_macros.svh =====
// Assertion macros for the masked byte pattern scanner.
// Included by the top level; depends on nothing else.
`ifndef MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MBPS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MBPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mbps_pkg.sv =====
// Shared sizes, register indexes and inter-module structs for the scanner.
// Used by every module of the masked byte pattern scanner; no dependencies.
package mbps_pkg;

    localparam int MAX_PATTERN_BYTES = 24;
    localparam int OFFSET_BITS       = 32;
    localparam int MATCH_OFFSET_W    = 32;
    localparam int LEN_BITS          = 5;
    localparam int CFG_WORD_W        = 64;
    localparam int CFG_WORDS         = 3;
    localparam int CFG_INDEX_W       = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK0    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK1    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK2    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH   = 3'd6;

    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] byte_vec_t;
    typedef logic [CFG_WORDS-1:0][CFG_WORD_W-1:0] cfg_words_t;

    typedef struct packed {
        byte_vec_t           pattern;
        byte_vec_t           mask;
        logic [LEN_BITS-1:0] length;
    } cfg_t;

    // Window stage status: word held, last flag, saturated byte count
    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic [OFFSET_BITS-1:0] seen;
    } win_stat_t;

    typedef struct packed {
        logic                      hit;
        logic [MATCH_OFFSET_W-1:0] offset;
    } match_t;

    typedef struct packed {
        logic take;
        logic produce;
        logic reported;
    } out_stat_t;

endpackage

// ===== rtl/core/masked_byte_pattern_scanner.sv =====
// Channel   Direction  Ports
// s_        in         s_valid s_ready s_data_byte s_last_byte
// m_        out        m_valid m_ready m_found m_match_offset
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data
//
// One byte per cycle while s_ready is high: a byte is shifted into the window
// register, compared against the pattern from that register, and any result
// lands in the output register. Reset (aresetn, synchronous, active low)
// clears the flags, the count and the config, not the data registers.
// A stalled result holds the compare stage; s_ready drops only while both
// the window stage and the output register are full and m_ready is low.
`include "masked_byte_pattern_scanner_macros.svh"

module masked_byte_pattern_scanner (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_data_byte,
    input  logic                                  s_last_byte,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_found,
    output logic [mbps_pkg::MATCH_OFFSET_W-1:0]   m_match_offset,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mbps_pkg::CFG_WORD_W-1:0]       cfg_data
);
    import mbps_pkg::*;

    cfg_t      cfg;
    byte_vec_t window;
    win_stat_t stat;
    match_t    match;
    out_stat_t ostat;

    mbps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbps_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .take        (ostat.take),
        .window      (window),
        .stat        (stat)
    );

    mbps_match u_match (
        .cfg    (cfg),
        .window (window),
        .seen   (stat.seen),
        .match  (match)
    );

    mbps_out u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .stat           (stat),
        .match          (match),
        .ostat          (ostat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_match_offset (m_match_offset)
    );

    // Checks
    `MBPS_ASSERT_NOW(a_miss_offset_zero, aclk, aresetn, m_valid && !m_found, m_match_offset == '0, "not-found result with nonzero offset")
    `MBPS_ASSERT_NEXT(a_stage_held, aclk, aresetn, stat.valid && !ostat.take, stat.valid, "window stage word lost while stalled")
    `MBPS_ASSERT_NEXT(a_reported_set, aclk, aresetn, ostat.produce && match.hit && !stat.last, ostat.reported, "match reported flag not set after found result")
    `MBPS_ASSERT_NOW(a_miss_on_last, aclk, aresetn, ostat.produce && !match.hit, stat.last, "not-found result on a byte that is not last")

endmodule

// ===== rtl/core/mbps_cfg.sv =====
// Configuration register file: pattern, mask and length registers.
// Depends on mbps_pkg.
module mbps_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbps_pkg::CFG_WORD_W-1:0]  cfg_data,
    output mbps_pkg::cfg_t                   cfg
);
    import mbps_pkg::*;

    cfg_words_t          pattern_reg, pattern_next;
    cfg_words_t          mask_reg, mask_next;
    logic [LEN_BITS-1:0] length_reg, length_next;
    logic                wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    // Decode the register index; unknown indexes are dropped
    always_comb begin
        pattern_next = pattern_reg;
        mask_next    = mask_reg;
        length_next  = length_reg;
        if (wr_en) begin
            case (cfg_index)
                REG_PATTERN0: pattern_next[0] = cfg_data;
                REG_PATTERN1: pattern_next[1] = cfg_data;
                REG_PATTERN2: pattern_next[2] = cfg_data;
                REG_MASK0:    mask_next[0]    = cfg_data;
                REG_MASK1:    mask_next[1]    = cfg_data;
                REG_MASK2:    mask_next[2]    = cfg_data;
                REG_LENGTH:   length_next     = cfg_data[LEN_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            mask_reg    <= '0;
            length_reg  <= '0;
        end else begin
            pattern_reg <= pattern_next;
            mask_reg    <= mask_next;
            length_reg  <= length_next;
        end
    end

    // Byte i of the pattern sits in bits 8i+7..8i of the concatenated words
    assign cfg.pattern = byte_vec_t'(pattern_reg);
    assign cfg.mask    = byte_vec_t'(mask_reg);
    assign cfg.length  = length_reg;

endmodule

// ===== rtl/core/mbps_window.sv =====
// Input stage: byte window shift line, saturating byte count and last flag.
// Depends on mbps_pkg.
module mbps_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_last_byte,
    input  logic                take,
    output mbps_pkg::byte_vec_t window,
    output mbps_pkg::win_stat_t stat
);
    import mbps_pkg::*;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

    byte_vec_t              window_reg, window_next;
    logic [OFFSET_BITS-1:0] seen_reg, seen_next;
    logic                   last_reg, last_next;
    logic                   valid_reg, valid_next;
    logic                   accept;

    // Take a word when the stage is empty or is draining this cycle
    assign s_ready = !valid_reg || take;
    assign accept  = s_valid && s_ready;

    // Shift the new byte in at the top; restart the count after a last byte.
    // Slots older than the count are never compared, so no clearing is needed.
    always_comb begin
        window_next = window_reg;
        seen_next   = seen_reg;
        last_next   = last_reg;
        valid_next  = valid_reg;
        if (accept) begin
            window_next = {s_data_byte, window_reg[MAX_PATTERN_BYTES-1:1]};
            if (last_reg) begin
                seen_next = OFFSET_BITS'(1);
            end else if (seen_reg != COUNT_MAX) begin
                seen_next = seen_reg + OFFSET_BITS'(1);
            end
            last_next  = s_last_byte;
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;
        if (!aresetn) begin
            seen_reg  <= '0;
            last_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            seen_reg  <= seen_next;
            last_reg  <= last_next;
            valid_reg <= valid_next;
        end
    end

    assign window     = window_reg;
    assign stat.valid = valid_reg;
    assign stat.last  = last_reg;
    assign stat.seen  = seen_reg;

endmodule

// ===== rtl/core/mbps_match.sv =====
// Parallel masked compare of the byte window against the pattern.
// Depends on mbps_pkg.
module mbps_match (
    input  mbps_pkg::cfg_t                          cfg,
    input  mbps_pkg::byte_vec_t                     window,
    input  logic [mbps_pkg::OFFSET_BITS-1:0]        seen,
    output mbps_pkg::match_t                        match
);
    import mbps_pkg::*;

    logic                   len_ok;
    logic                   seen_ok;
    logic                   all_ok;
    logic                   pre_anchor;
    logic [OFFSET_BITS-1:0] start;

    // The window tail of length bytes lines up with pattern bytes 0..length-1
    always_comb begin
        logic [LEN_BITS-1:0] slot;
        logic [7:0]          b;
        logic [7:0]          m;
        logic [7:0]          p;
        logic                in_use;
        all_ok     = 1'b1;
        pre_anchor = 1'b1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            slot   = LEN_BITS'(MAX_PATTERN_BYTES) - cfg.length + LEN_BITS'(i);
            b      = (slot < LEN_BITS'(MAX_PATTERN_BYTES)) ? window[slot] : 8'h00;
            m      = cfg.mask[i];
            p      = cfg.pattern[i];
            in_use = LEN_BITS'(i) < cfg.length;
            if (in_use && pre_anchor && (m != 8'h00)) begin
                // anchor byte: exact and masked compare
                all_ok     = all_ok && (b == p) && ((b & m) == p);
                pre_anchor = 1'b0;
            end else if (in_use && !pre_anchor) begin
                all_ok = all_ok && ((b & m) == p);
            end
        end
    end

    assign len_ok  = (cfg.length != '0) && (cfg.length <= LEN_BITS'(MAX_PATTERN_BYTES));
    assign seen_ok = seen >= OFFSET_BITS'(cfg.length);
    assign start   = seen - OFFSET_BITS'(cfg.length);

    assign match.hit    = len_ok && seen_ok && !pre_anchor && all_ok;
    assign match.offset = MATCH_OFFSET_W'(start);

endmodule

// ===== rtl/core/mbps_out.sv =====
// Result register, reported flag and the drain decision for the input stage.
// Depends on mbps_pkg.
module mbps_out (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mbps_pkg::win_stat_t                   stat,
    input  mbps_pkg::match_t                      match,
    output mbps_pkg::out_stat_t                   ostat,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_found,
    output logic [mbps_pkg::MATCH_OFFSET_W-1:0]   m_match_offset
);
    import mbps_pkg::*;

    logic                      valid_reg, valid_next;
    logic                      found_reg, found_next;
    logic [MATCH_OFFSET_W-1:0] offset_reg, offset_next;
    logic                      reported_reg, reported_next;
    logic                      take;
    logic                      hit;
    logic                      miss;
    logic                      produce;

    // Drain the window stage when the result register is free or leaving
    assign take    = stat.valid && (!valid_reg || m_ready);
    assign hit     = !reported_reg && match.hit;
    assign miss    = stat.last && !reported_reg && !match.hit;
    assign produce = take && (hit || miss);

    always_comb begin
        valid_next    = valid_reg;
        found_next    = found_reg;
        offset_next   = offset_reg;
        reported_next = reported_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (produce) begin
            valid_next  = 1'b1;
            found_next  = hit;
            offset_next = hit ? match.offset : '0;
        end
        // Re-arm after the last byte, else hold once a match is out
        if (take) begin
            if (stat.last) begin
                reported_next = 1'b0;
            end else if (hit) begin
                reported_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        found_reg  <= found_next;
        offset_reg <= offset_next;
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            reported_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            reported_reg <= reported_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_found        = found_reg;
    assign m_match_offset = offset_reg;

    assign ostat.take     = take;
    assign ostat.produce  = produce;
    assign ostat.reported = reported_reg;

endmodule
